// File: hdl/lane_tangent_steer_error_defines.svh
// ----------------------------------------------------------------------------
// Lane tangent steering error: assertion macros
// Shared macros for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef LANE_TANGENT_STEER_ERROR_DEFINES_SVH
`define LANE_TANGENT_STEER_ERROR_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define LTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lts check failed");

// Next-cycle implication, disabled while reset is held.
`define LTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lts check failed");

`endif

// File: hdl/lts_pkg.sv
// ----------------------------------------------------------------------------
// Lane tangent steering error: package
// Beat types, register codes and fixed constants of the block.
// ----------------------------------------------------------------------------
package lts_pkg;

    // Row window of one frame.
    localparam logic [6:0] FIRST_ROW    = 7'd30;
    localparam logic [6:0] ROW_END      = 7'd80;
    localparam logic [6:0] LOST_ROW_MIN = 7'd40;
    localparam logic [6:0] ROW_MAX      = 7'd127;

    // Lost-edge counting.
    localparam logic [7:0] TRACK_COUNT_LIM = 8'd75;
    localparam logic [3:0] LOST_MAX        = 4'd10;

    // Slope jump window.
    localparam logic signed [16:0] JUMP_LIM = 17'sd400;

    // Frame-start slope values.
    localparam logic signed [15:0] LEFT_BEST_INIT  = 16'sh8000;
    localparam logic signed [15:0] RIGHT_BEST_INIT = 16'sh7FFF;

    // Register reset values.
    localparam logic [7:0] NEAR_LIMIT_RST  = 8'd0;
    localparam logic [7:0] FAR_LIMIT_RST   = 8'd255;
    localparam logic [6:0] DEFAULT_ROW_RST = 7'd80;
    localparam logic [7:0] STEP_LIMIT_RST  = 8'd30;
    localparam logic [9:0] ERR_LIMIT_RST   = 10'd200;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEAR_LIMIT  = 3'd0,
        CFG_FAR_LIMIT   = 3'd1,
        CFG_DEFAULT_ROW = 3'd2,
        CFG_STEP_LIMIT  = 3'd3,
        CFG_ERR_LIMIT   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0]         left_row_pos;
        logic [7:0]         right_row_pos;
        logic signed [15:0] left_slope;
        logic signed [15:0] right_slope;
        logic               left_missing;
        logic               right_missing;
        logic               plain_track;
        logic [7:0]         track_count_now;
        logic               last_row;
    } t_in_beat;

    typedef struct packed {
        logic signed [10:0] steer_err;
        logic [6:0]         left_tangent_row;
        logic [6:0]         right_tangent_row;
    } t_out_beat;

endpackage

// File: hdl/lane_tangent_steer_error.sv
// ----------------------------------------------------------------------------
// Lane tangent steering error
// Per-row tangent slope tracking with a rate-limited, clamped frame error.
// ----------------------------------------------------------------------------
// One row beat is taken per clock while results drain. A row beat is
// registered in A, then updates the frame state as it leaves A (best and
// committed slopes, tangent rows, lost runs, row counter, scan stop) through
// a single compare/add layer that feeds back on itself every cycle. On the
// frame's last row the committed slope sum and the tangent rows move to a
// second register; the step limit against the previous frame's error and the
// magnitude clamp are applied on the way into the result register. A result
// beat therefore passes through A, B and the result register in turn.
// Rows that cause no result never wait on the output side; a last row waits
// only while both result stages are full. Configuration writes are taken in
// any cycle and act on the following rows; default_row takes effect at the
// next frame start.
module lane_tangent_steer_error
    import lts_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_beat              i_in_beat,

    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_beat             o_out_beat,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0] r_near_limit;
    logic [7:0] r_far_limit;
    logic [6:0] r_default_row;
    logic [7:0] r_step_limit;
    logic [9:0] r_err_limit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near_limit  <= NEAR_LIMIT_RST;
            r_far_limit   <= FAR_LIMIT_RST;
            r_default_row <= DEFAULT_ROW_RST;
            r_step_limit  <= STEP_LIMIT_RST;
            r_err_limit   <= ERR_LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_NEAR_LIMIT:  r_near_limit  <= i_cfg_data[7:0];
                CFG_FAR_LIMIT:   r_far_limit   <= i_cfg_data[7:0];
                CFG_DEFAULT_ROW: r_default_row <= i_cfg_data[6:0];
                CFG_STEP_LIMIT:  r_step_limit  <= i_cfg_data[7:0];
                CFG_ERR_LIMIT:   r_err_limit   <= i_cfg_data[9:0];
                default: ;  // writes past the list are dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake
    //   A: input register, B: committed sum of a finished frame,
    //   C: result register (rate limit and clamp applied on entry).
    // ------------------------------------------------------------------
    logic     r_a_valid;
    t_in_beat r_a;
    logic     r_b_valid;
    logic     r_out_valid;
    logic     c_ready;
    logic     b_ready;
    logic     b_go;
    logic     a_go;

    assign c_ready    = !r_out_valid || i_out_ready;
    assign b_ready    = !r_b_valid || c_ready;
    assign b_go       = r_b_valid && c_ready;
    // Only a last row needs room downstream.
    assign a_go       = r_a_valid && (!r_a.last_row || b_ready);
    assign o_in_ready = !r_a_valid || a_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_a <= i_in_beat;
        end
    end

    // ------------------------------------------------------------------
    // Frame state
    // ------------------------------------------------------------------
    logic signed [15:0] r_left_best,      n_left_best;
    logic signed [15:0] r_right_best,     n_right_best;
    logic signed [15:0] r_left_committed, n_left_committed;
    logic signed [15:0] r_right_committed, n_right_committed;
    logic [6:0]         r_left_row_sel,   n_left_row_sel;
    logic [6:0]         r_right_row_sel,  n_right_row_sel;
    logic [3:0]         r_left_lost_run,  n_left_lost_run;
    logic [3:0]         r_right_lost_run, n_right_lost_run;
    logic [6:0]         r_row_counter,    n_row_counter;
    logic               r_scan_stopped,   n_scan_stopped;

    logic [8:0]         pos_sum;
    logic [11:0]        pos_sum_x5;
    logic [11:0]        pos_sum_x2;
    logic [11:0]        near_x8;
    logic [11:0]        far_x5;
    logic               scan_on;
    logic               counting;
    logic               lost_rows;
    logic               left_active;
    logic               right_active;
    logic signed [16:0] left_jump;
    logic signed [16:0] right_jump;
    logic               left_take;
    logic               right_take;
    logic               stop;

    always_comb begin
        pos_sum    = {1'b0, r_a.left_row_pos} + {1'b0, r_a.right_row_pos};
        pos_sum_x5 = {1'b0, pos_sum, 2'b00} + {3'b000, pos_sum};
        pos_sum_x2 = {2'b00, pos_sum, 1'b0};
        near_x8    = {1'b0, r_near_limit, 3'b000};
        far_x5     = {2'b00, r_far_limit, 2'b00} + {4'b0000, r_far_limit};

        // Near rows are skipped; rows past the window or after a stop are ignored.
        scan_on   = !r_scan_stopped && (r_row_counter < ROW_END)
                    && !(pos_sum_x5 < near_x8);
        counting  = r_a.plain_track && (r_a.track_count_now < TRACK_COUNT_LIM);
        lost_rows = r_row_counter > LOST_ROW_MIN;

        left_active  = r_left_lost_run < LOST_MAX;
        right_active = r_right_lost_run < LOST_MAX;

        // Jump check uses the best held before this row.
        left_jump  = {r_left_best[15], r_left_best}
                   - {r_left_committed[15], r_left_committed};
        right_jump = {r_right_best[15], r_right_best}
                   - {r_right_committed[15], r_right_committed};

        left_take  = scan_on && left_active && (r_a.left_slope > r_left_best)
                     && (left_jump < JUMP_LIM) && (left_jump > -JUMP_LIM);
        right_take = scan_on && right_active && (r_a.right_slope < r_right_best)
                     && (right_jump < JUMP_LIM) && (right_jump > -JUMP_LIM);

        n_left_lost_run = r_left_lost_run;
        if (scan_on && left_active && lost_rows) begin
            n_left_lost_run = (r_a.left_missing && counting) ?
                              r_left_lost_run + 4'd1 : 4'd0;
        end
        n_right_lost_run = r_right_lost_run;
        if (scan_on && right_active && lost_rows) begin
            n_right_lost_run = (r_a.right_missing && counting) ?
                               r_right_lost_run + 4'd1 : 4'd0;
        end

        n_left_best     = left_take  ? r_a.left_slope  : r_left_best;
        n_left_row_sel  = left_take  ? r_row_counter   : r_left_row_sel;
        n_right_best    = right_take ? r_a.right_slope : r_right_best;
        n_right_row_sel = right_take ? r_row_counter   : r_right_row_sel;

        // Crossed slopes or a far row end the scan; otherwise commit.
        stop = (n_left_best > n_right_best) || (pos_sum_x2 > far_x5);

        n_scan_stopped    = r_scan_stopped;
        n_left_committed  = r_left_committed;
        n_right_committed = r_right_committed;
        if (scan_on) begin
            if (stop) begin
                n_scan_stopped = 1'b1;
            end else begin
                n_left_committed  = n_left_best;
                n_right_committed = n_right_best;
            end
        end

        n_row_counter = (r_row_counter < ROW_MAX) ? r_row_counter + 7'd1 : r_row_counter;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_best       <= LEFT_BEST_INIT;
            r_right_best      <= RIGHT_BEST_INIT;
            r_left_committed  <= '0;
            r_right_committed <= '0;
            r_left_row_sel    <= DEFAULT_ROW_RST;
            r_right_row_sel   <= DEFAULT_ROW_RST;
            r_left_lost_run   <= '0;
            r_right_lost_run  <= '0;
            r_row_counter     <= FIRST_ROW;
            r_scan_stopped    <= 1'b0;
        end else if (a_go) begin
            if (r_a.last_row) begin
                // frame start
                r_left_best       <= LEFT_BEST_INIT;
                r_right_best      <= RIGHT_BEST_INIT;
                r_left_committed  <= '0;
                r_right_committed <= '0;
                r_left_row_sel    <= r_default_row;
                r_right_row_sel   <= r_default_row;
                r_left_lost_run   <= '0;
                r_right_lost_run  <= '0;
                r_row_counter     <= FIRST_ROW;
                r_scan_stopped    <= 1'b0;
            end else begin
                r_left_best       <= n_left_best;
                r_right_best      <= n_right_best;
                r_left_committed  <= n_left_committed;
                r_right_committed <= n_right_committed;
                r_left_row_sel    <= n_left_row_sel;
                r_right_row_sel   <= n_right_row_sel;
                r_left_lost_run   <= n_left_lost_run;
                r_right_lost_run  <= n_right_lost_run;
                r_row_counter     <= n_row_counter;
                r_scan_stopped    <= n_scan_stopped;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage B: finished frame (slope sum and tangent rows)
    // ------------------------------------------------------------------
    logic signed [16:0] r_b_sum;
    logic [6:0]         r_b_left_row;
    logic [6:0]         r_b_right_row;
    logic               a_emit;

    assign a_emit = a_go && r_a.last_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= a_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_emit) begin
            r_b_sum       <= {n_left_committed[15], n_left_committed}
                           + {n_right_committed[15], n_right_committed};
            r_b_left_row  <= n_left_row_sel + 7'd1;
            r_b_right_row <= n_right_row_sel + 7'd1;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: step limit against the previous frame, then clamp
    // ------------------------------------------------------------------
    logic signed [10:0] r_prev_err;
    logic signed [17:0] prev_x;
    logic signed [17:0] step_x;
    logic signed [17:0] lim_x;
    logic signed [17:0] err_delta;
    logic signed [17:0] err_step;
    logic signed [17:0] err_clamp;
    t_out_beat          r_out;

    always_comb begin
        prev_x    = {{7{r_prev_err[10]}}, r_prev_err};
        step_x    = {10'd0, r_step_limit};
        lim_x     = {8'd0, r_err_limit};
        err_delta = {r_b_sum[16], r_b_sum} - prev_x;
        if (err_delta > step_x) begin
            err_step = prev_x + step_x;
        end else if (err_delta < -step_x) begin
            err_step = prev_x - step_x;
        end else begin
            err_step = {r_b_sum[16], r_b_sum};
        end
        if (err_step > lim_x) begin
            err_clamp = lim_x;
        end else if (err_step < -lim_x) begin
            err_clamp = -lim_x;
        end else begin
            err_clamp = err_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_prev_err  <= '0;
        end else begin
            if (c_ready) begin
                r_out_valid <= r_b_valid;
            end
            if (b_go) begin
                r_prev_err <= err_clamp[10:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_go) begin
            r_out.steer_err         <= err_clamp[10:0];
            r_out.left_tangent_row  <= r_b_left_row;
            r_out.right_tangent_row <= r_b_right_row;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule

// File: hdl/lts_checker.sv
// ----------------------------------------------------------------------------
// Lane tangent steering error: port checker
// Concurrent checks on the top level's ports, bound to every instance.
// ----------------------------------------------------------------------------
`include "lane_tangent_steer_error_defines.svh"

module lts_checker
    import lts_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input t_out_beat             o_out_beat,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready
);

    logic out_stall;

    assign out_stall = o_out_valid && !i_out_ready;

    // A stalled result beat holds.
    `LTS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(o_out_beat))

    // With no result waiting, rows are never held off.
    `LTS_ASSERT_NOW(a_in_free, i_clk, i_rst_n, !o_out_valid, o_in_ready)

    // Register writes are always taken.
    `LTS_ASSERT_NOW(a_cfg_free, i_clk, i_rst_n, i_cfg_valid, o_cfg_ready)

    // The clamp is symmetric, so the most negative code never shows.
    `LTS_ASSERT_NOW(a_err_range, i_clk, i_rst_n, o_out_valid, o_out_beat.steer_err != 11'sh400)

endmodule

bind lane_tangent_steer_error lts_checker u_lts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_beat  (o_out_beat),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready)
);

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Lane tangent steering error: block-level testbench
// Row beats go in over a valid/ready channel. A predictor written in SV
// follows the frame state and queues the expected frame result beats, and
// each result beat taken from the block is compared against the oldest one.
// A short directed run comes first, then random frames under several
// register settings and idle patterns.
// ----------------------------------------------------------------------------
module testbench;
    import lts_pkg::*;

    // Unused register index; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd6;

    // A last row passes through the block's registers before its result shows; leave some margin.
    localparam int RESULT_LAT  = 4;
    localparam int RANDOM_ROWS = 800;
    localparam int PHASE_ROWS  = 150;
    localparam int DRAIN_LIMIT = 20000;

    // ------------------------------------------------------------------
    // Frame predictor and store of expected frame results
    // ------------------------------------------------------------------
    class lane_steer_tracker;
        // register copies
        logic [7:0] near_lim;
        logic [7:0] far_lim;
        logic [6:0] dflt_row;
        logic [7:0] step_lim;
        logic [9:0] err_lim;

        // frame state
        logic signed [15:0] l_best;
        logic signed [15:0] r_best;
        logic signed [15:0] l_commit;
        logic signed [15:0] r_commit;
        logic [6:0]         l_row;
        logic [6:0]         r_row;
        logic [3:0]         l_lost;
        logic [3:0]         r_lost;
        logic [6:0]         row_cnt;
        bit                 stopped;

        // survives frame boundaries, cleared at reset only
        int prev_err;

        t_out_beat pending_errs[$];
        int        n_errors;
        int        n_checked;

        function new();
            near_lim  = NEAR_LIMIT_RST;
            far_lim   = FAR_LIMIT_RST;
            dflt_row  = DEFAULT_ROW_RST;
            step_lim  = STEP_LIMIT_RST;
            err_lim   = ERR_LIMIT_RST;
            prev_err  = 0;
            n_errors  = 0;
            n_checked = 0;
            start_frame();
        endfunction

        function void start_frame();
            l_best   = LEFT_BEST_INIT;
            r_best   = RIGHT_BEST_INIT;
            l_commit = '0;
            r_commit = '0;
            l_row    = dflt_row;
            r_row    = dflt_row;
            l_lost   = '0;
            r_lost   = '0;
            row_cnt  = FIRST_ROW;
            stopped  = 1'b0;
        endfunction

        function int abs_int(int v);
            return (v < 0) ? -v : v;
        endfunction

        // default_row only lands at the next frame start
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_NEAR_LIMIT:  near_lim = data[7:0];
                CFG_FAR_LIMIT:   far_lim  = data[7:0];
                CFG_DEFAULT_ROW: dflt_row = data[6:0];
                CFG_STEP_LIMIT:  step_lim = data[7:0];
                CFG_ERR_LIMIT:   err_lim  = data[9:0];
                default: ;
            endcase
        endfunction

        // one accepted row beat
        function void take_row(t_in_beat b);
            int        psum;
            int        ls;
            int        rs;
            int        lb;
            int        rb;
            int        lc;
            int        rc;
            int        target;
            int        step_max;
            int        mag_max;
            bit        counting;
            logic [6:0] y;
            t_out_beat want;

            psum = int'(b.left_row_pos) + int'(b.right_row_pos);
            ls   = $signed(b.left_slope);
            rs   = $signed(b.right_slope);
            y    = row_cnt;

            if (!stopped && y < ROW_END && 5 * psum >= 8 * int'(near_lim)) begin
                counting = b.plain_track && (b.track_count_now < TRACK_COUNT_LIM);
                if (l_lost < LOST_MAX) begin
                    if (y > LOST_ROW_MIN)
                        l_lost = (b.left_missing && counting) ? l_lost + 4'd1 : 4'd0;
                    lb = l_best;
                    lc = l_commit;
                    if (ls > lb && abs_int(lb - lc) < int'(JUMP_LIM)) begin
                        l_best = b.left_slope;
                        l_row  = y;
                    end
                end
                if (r_lost < LOST_MAX) begin
                    if (y > LOST_ROW_MIN)
                        r_lost = (b.right_missing && counting) ? r_lost + 4'd1 : 4'd0;
                    rb = r_best;
                    rc = r_commit;
                    if (rs < rb && abs_int(rb - rc) < int'(JUMP_LIM)) begin
                        r_best = b.right_slope;
                        r_row  = y;
                    end
                end
                lb = l_best;
                rb = r_best;
                if (lb > rb || 2 * psum > 5 * int'(far_lim)) begin
                    stopped = 1'b1;
                end else begin
                    l_commit = l_best;
                    r_commit = r_best;
                end
            end
            if (row_cnt < ROW_MAX)
                row_cnt = row_cnt + 7'd1;

            if (b.last_row) begin
                lc       = l_commit;
                rc       = r_commit;
                target   = lc + rc;
                step_max = int'(step_lim);
                mag_max  = int'(err_lim);
                if (target - prev_err > step_max)
                    target = prev_err + step_max;
                else if (target - prev_err < -step_max)
                    target = prev_err - step_max;
                if (target > mag_max)
                    target = mag_max;
                else if (target < -mag_max)
                    target = -mag_max;
                prev_err = target;
                want.steer_err         = target[10:0];
                want.left_tangent_row  = l_row + 7'd1;
                want.right_tangent_row = r_row + 7'd1;
                pending_errs.push_back(want);
                start_frame();
            end
        endfunction

        // one accepted result beat
        function void check_result(t_out_beat got);
            t_out_beat want;
            if (pending_errs.size() == 0) begin
                n_errors++;
                $error("result beat with no frame waiting: steer_err %0d",
                       $signed(got.steer_err));
                return;
            end
            want = pending_errs.pop_front();
            n_checked++;
            if (got.steer_err !== want.steer_err) begin
                n_errors++;
                $error("steer_err: expected %0d, got %0d",
                       $signed(want.steer_err), $signed(got.steer_err));
            end
            if (got.left_tangent_row !== want.left_tangent_row) begin
                n_errors++;
                $error("left_tangent_row: expected %0d, got %0d",
                       want.left_tangent_row, got.left_tangent_row);
            end
            if (got.right_tangent_row !== want.right_tangent_row) begin
                n_errors++;
                $error("right_tangent_row: expected %0d, got %0d",
                       want.right_tangent_row, got.right_tangent_row);
            end
        endfunction

        function void report_leftover();
            if (pending_errs.size() != 0) begin
                n_errors += pending_errs.size();
                $error("%0d frame results never came out", pending_errs.size());
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Block hookup; every input starts at a known value
    // ------------------------------------------------------------------
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in_beat              i_in_beat   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_beat             o_out_beat;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    lane_tangent_steer_error DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    lane_steer_tracker tracker;

    // idle percentages, changed per phase
    int send_idle_pct = 0;
    int stall_pct     = 0;

    // run statistics for the closing summary
    int dir_rows   = 0;
    int rnd_rows   = 0;
    int n_settings = 0;
    int n_pauses   = 0;

    // 12-unit clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver: ready is redrawn every cycle. Ready may drop with a result
    // beat still pending; that is legal on the output side.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Monitor. Runs right at the edge, so it sees the values that were
    // stable before the edge, i.e. exactly what the block sampled.
    // A result can never belong to a row taken at the same edge (it must
    // pass the block's registers first), so checking before predicting is safe.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                tracker.write_reg(i_cfg_index, i_cfg_data);
            if (o_out_valid && i_out_ready)
                tracker.check_result(o_out_beat);
            if (i_in_valid && o_in_ready)
                tracker.take_row(i_in_beat);
        end
    end

    // Watchdog: generous fixed time, far above the slowest legal run.
    initial begin
        #3000000;
        $display("testbench failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------

    // One row beat. Random idle cycles come first; once valid goes up it
    // stays up with a steady payload until the beat is taken.
    task automatic send_row(input t_in_beat b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= b;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
    endtask

    // One register beat; valid is left high so writes can go back to back.
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
    endtask

    // Whole register set. Unused high data bits get junk now and then.
    task automatic set_regs(input int near, input int far, input int drow,
                            input int step_v, input int elim);
        logic [CFG_DATA_W-1:0] junk;
        junk = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom) : '0;
        write_cfg(CFG_NEAR_LIMIT,  {junk[9:8], near[7:0]});
        write_cfg(CFG_FAR_LIMIT,   {junk[9:8], far[7:0]});
        write_cfg(CFG_DEFAULT_ROW, {junk[9:7], drow[6:0]});
        write_cfg(CFG_STEP_LIMIT,  {junk[9:8], step_v[7:0]});
        write_cfg(CFG_ERR_LIMIT,   elim[9:0]);
        if ($urandom_range(0, 2) == 0)
            write_cfg(CFG_IDX_SPARE, CFG_DATA_W'($urandom));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        n_settings++;
    endtask

    // Sender holds off until every frame result is out, then keeps waiting
    // so that no row is still in flight inside the block.
    task automatic drain_results();
        int n;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        for (n = 0; n < DRAIN_LIMIT && tracker.pending_errs.size() != 0; n++)
            @(posedge i_clk);
        repeat (RESULT_LAT) @(posedge i_clk);
    endtask

    function automatic t_in_beat row_beat(int lpos, int rpos, int lsl, int rsl,
                                          bit lm, bit rm, bit pl, int tc, bit lastr);
        t_in_beat b;
        b.left_row_pos    = lpos[7:0];
        b.right_row_pos   = rpos[7:0];
        b.left_slope      = lsl[15:0];
        b.right_slope     = rsl[15:0];
        b.left_missing    = lm;
        b.right_missing   = rm;
        b.plain_track     = pl;
        b.track_count_now = tc[7:0];
        b.last_row        = lastr;
        return b;
    endfunction

    function automatic int clamp16(int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // Directed frames; run with near 20, far 200, default row 127.
    task automatic run_directed();
        int y;
        int lsl;
        int rsl;
        int pos;
        // Crossing stop. Row 30 carries field extremes and is never taken
        // (jump check against the far-off start values); row 31 takes both
        // sides, so both tangent rows come out as 32, and crosses.
        send_row(row_beat(0, 255, 32767, -32768, 1, 1, 0, 255, 0));
        send_row(row_beat(255, 0, 500, -500, 0, 0, 1, 0, 0));
        send_row(row_beat(128, 128, -1, -1, 0, 0, 1, 74, 1));
        dir_rows += 3;

        // Plain tracking: a skipped near row, left edge lost for ten rows
        // past row 40 so the left side freezes, a row that would cross if
        // the left were still live, then a far stop on the last row.
        for (y = 30; y <= 52; y++) begin
            lsl = -1000 + 10 * (y - 30);
            rsl = 1000 - 10 * (y - 30);
            pos = 100;
            if (y == 32) begin
                pos = 10;
                lsl = 30000;
            end
            if (y == 51)
                lsl = 900;
            if (y == 52)
                pos = 255;
            send_row(row_beat(pos, pos, lsl, rsl, (y >= 41 && y <= 50), (y == 45),
                              (y != 35), (y == 36) ? 255 : 0, (y == 52)));
        end
        dir_rows += 23;

        // Nothing taken: tangent rows fall back to default row 127, whose
        // plus-one wraps to zero.
        send_row(row_beat(100, 100, -32768, 32767, 0, 0, 1, 0, 0));
        send_row(row_beat(100, 100, -32768, 32767, 0, 0, 1, 0, 1));
        dir_rows += 2;
    endtask

    // One random frame of len rows. Well-formed frames mostly keep the row
    // distances inside the near/far window and mostly move the slopes slowly,
    // so the scan gets deep; noise frames are random beats but for last_row.
    task automatic run_frame(input bit noise, input int len);
        int         lsl;
        int         rsl;
        int         lo;
        int         hi;
        int         psum;
        int         lpos;
        int         rpos;
        int         miss_pct;
        int         r;
        int         i;
        bit         plain_frame;
        logic [63:0] raw;
        t_in_beat   b;

        lsl = int'($urandom_range(0, 3000)) - 3000;
        rsl = int'($urandom_range(0, 3000));
        case ($urandom_range(0, 2))
            0:       miss_pct = 0;
            1:       miss_pct = 20;
            default: miss_pct = 95;
        endcase
        plain_frame = ($urandom_range(0, 9) != 0);
        lo = (8 * int'(tracker.near_lim) + 4) / 5;
        hi = (5 * int'(tracker.far_lim)) / 2;
        if (hi > 510)
            hi = 510;

        for (i = 0; i < len; i++) begin
            if (noise) begin
                raw        = {$urandom, $urandom};
                b          = raw[59:0];
                b.last_row = (i == len - 1);
            end else begin
                if (lo <= hi && $urandom_range(0, 99) < 85)
                    psum = int'($urandom_range(lo, hi));
                else
                    psum = int'($urandom_range(0, 510));
                lpos = int'($urandom_range((psum > 255) ? psum - 255 : 0,
                                           (psum < 255) ? psum : 255));
                rpos = psum - lpos;

                r = $urandom_range(0, 99);
                if (r < 5)
                    lsl = lsl + int'($urandom_range(500, 3000));   // left jump
                else if (r < 10)
                    rsl = rsl - int'($urandom_range(500, 3000));   // right jump
                else if (r < 13)
                    lsl = rsl + int'($urandom_range(1, 500));      // force a cross
                else if (r == 13)
                    lsl = 32767;
                else if (r == 14)
                    rsl = -32768;
                else begin
                    lsl = lsl + int'($urandom_range(0, 150)) - 40;
                    rsl = rsl - int'($urandom_range(0, 150)) + 40;
                end
                lsl = clamp16(lsl);
                rsl = clamp16(rsl);

                b.left_row_pos    = lpos[7:0];
                b.right_row_pos   = rpos[7:0];
                b.left_slope      = lsl[15:0];
                b.right_slope     = rsl[15:0];
                b.left_missing    = ($urandom_range(0, 99) < miss_pct);
                b.right_missing   = ($urandom_range(0, 99) < miss_pct);
                b.plain_track     = plain_frame ^ ($urandom_range(0, 19) == 0);
                b.track_count_now = ($urandom_range(0, 4) != 0) ?
                                    8'($urandom_range(0, 74)) :
                                    8'($urandom_range(75, 255));
                b.last_row        = (i == len - 1);
            end
            send_row(b);
            rnd_rows++;
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        int phase;
        int phase_rows;
        int len;
        int r;
        int n;

        tracker = new();

        // synchronous reset, once
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, no idling
        set_regs(20, 200, 127, 30, 200);
        run_directed();
        drain_results();

        // Random phases. Registers change only between phases, with the
        // block drained. Idle pattern cycles: none, sender, receiver, both.
        phase = 0;
        while (rnd_rows < RANDOM_ROWS) begin
            case (phase)
                0:       set_regs(0, 255, 0, 255, 1023);
                1:       set_regs(255, 0, 127, 0, 0);
                default: set_regs($urandom_range(0, 60), $urandom_range(80, 255),
                                  $urandom_range(0, 127), $urandom_range(0, 255),
                                  $urandom_range(0, 1023));
            endcase
            case (phase % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 85;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 85;
                end
                default: begin
                    send_idle_pct = 28;
                    stall_pct     = 28;
                end
            endcase

            phase_rows = 0;
            while (phase_rows < PHASE_ROWS) begin
                // full-window frames, slightly more short ones (early last
                // row), some running past the window, a few long enough to
                // saturate the row counter
                r = $urandom_range(0, 99);
                if (r < 40)
                    len = $urandom_range(45, 55);
                else if (r < 85)
                    len = $urandom_range(1, 44);
                else if (r < 95)
                    len = $urandom_range(56, 100);
                else
                    len = $urandom_range(98, 130);
                run_frame(($urandom_range(0, 99) < 25), len);
                phase_rows += len;
                // sender holds off until all results are out
                if ($urandom_range(0, 9) == 0) begin
                    drain_results();
                    n_pauses++;
                end
            end
            drain_results();
            phase++;
        end

        // closing wait, bounded
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        for (n = 0; n < DRAIN_LIMIT && tracker.pending_errs.size() != 0; n++)
            @(posedge i_clk);
        repeat (2 * RESULT_LAT) @(posedge i_clk);
        tracker.report_leftover();

        $display("Covered %0d directed and %0d random row beats over %0d register sets,",
                 dir_rows, rnd_rows, n_settings);
        $display("four idle patterns and %0d mid-phase drains; %0d frame results compared.",
                 n_pauses, tracker.n_checked);
        if (tracker.n_errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// File: lane_tangent_steer_error.f
+incdir+hdl
hdl/lts_pkg.sv
hdl/lane_tangent_steer_error.sv
hdl/lts_checker.sv
tb/sv/testbench.sv
